// ===== rtl/assert_macros.svh =====
// assertion macros for the sd card spi host engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define SDH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define SDH_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/sdh_pkg.sv =====
// package: types, codes and framing helpers for the sd card spi host engine
package sdh_pkg;

    localparam int SECTOR_BYTES    = 512;
    localparam int INIT_IDLE_BYTES = 10;
    localparam int OUT_DEPTH       = 4;

    localparam logic [1:0] MODE_REQ   = 2'd0;
    localparam logic [1:0] MODE_CARD  = 2'd1;
    localparam logic [1:0] MODE_WDATA = 2'd2;

    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [1:0] KIND_XCHG   = 2'd0;
    localparam logic [1:0] KIND_RDATA  = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;
    localparam logic [1:0] KIND_WNEED  = 2'd3;

    localparam logic [2:0] CFG_RESP_WAIT = 3'd0;
    localparam logic [2:0] CFG_IDLE_RTRY = 3'd1;
    localparam logic [2:0] CFG_IFC_RTRY  = 3'd2;
    localparam logic [2:0] CFG_OPC_RTRY  = 3'd3;
    localparam logic [2:0] CFG_TOK_WAIT  = 3'd4;
    localparam logic [2:0] CFG_BUSY_WAIT = 3'd5;

    localparam logic [7:0]  BYTE_IDLE   = 8'hFF;
    localparam logic [7:0]  TOKEN_START = 8'hFE;
    localparam logic [7:0]  R1_IDLE     = 8'h01;
    localparam logic [7:0]  DRESP_MASK  = 8'h1F;
    localparam logic [7:0]  DRESP_OK    = 8'h05;
    localparam logic [7:0]  CRC_CMD8    = 8'h87;
    localparam logic [7:0]  CRC_OTHER   = 8'h95;
    localparam logic [31:0] ARG_IFCOND  = 32'h0000_01AA;
    localparam logic [31:0] ARG_HCS     = 32'h4000_0000;

    localparam logic [5:0] CMD_GO_IDLE = 6'd0;
    localparam logic [5:0] CMD_IFCOND  = 6'd8;
    localparam logic [5:0] CMD_APP     = 6'd55;
    localparam logic [5:0] CMD_OPCOND  = 6'd41;
    localparam logic [5:0] CMD_READ_OCR = 6'd58;
    localparam logic [5:0] CMD_READ1   = 6'd17;
    localparam logic [5:0] CMD_WRITE1  = 6'd24;

    typedef enum logic [4:0] {
        PH_IDLE, PH_INIT_IDLE, PH_CMD0, PH_GAP, PH_CMD8, PH_CMD55, PH_ACMD41,
        PH_CMD58, PH_RD_CMD, PH_RD_TOKEN, PH_RD_DATA, PH_WR_CMD, PH_WR_DATA,
        PH_WR_NEED, PH_WR_RESP, PH_WR_BUSY1, PH_WR_GAP, PH_WR_BUSY2
    } t_phase;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] tx;
        logic       sel;
        logic [7:0] rd;
        logic       st;
        logic       hc;
        logic       last;
    } t_res;

    function automatic logic [5:0] cmd_of(t_phase p);
        case (p)
            PH_CMD8:   cmd_of = CMD_IFCOND;
            PH_CMD55:  cmd_of = CMD_APP;
            PH_ACMD41: cmd_of = CMD_OPCOND;
            PH_CMD58:  cmd_of = CMD_READ_OCR;
            PH_RD_CMD: cmd_of = CMD_READ1;
            PH_WR_CMD: cmd_of = CMD_WRITE1;
            default:   cmd_of = CMD_GO_IDLE;
        endcase
    endfunction

    function automatic logic [7:0] frame_byte(logic [5:0] c, logic [31:0] arg, logic [3:0] k);
        case (k)
            4'd0:    frame_byte = {2'b01, c};
            4'd1:    frame_byte = arg[31:24];
            4'd2:    frame_byte = arg[23:16];
            4'd3:    frame_byte = arg[15:8];
            4'd4:    frame_byte = arg[7:0];
            default: frame_byte = (c == CMD_IFCOND) ? CRC_CMD8 : CRC_OTHER;
        endcase
    endfunction

    function automatic t_res mk_res(logic [1:0] kind, logic [7:0] tx, logic sel,
                                    logic [7:0] rd, logic st);
        t_res r;
        r.kind = kind;
        r.tx   = tx;
        r.sel  = sel;
        r.rd   = rd;
        r.st   = st;
        r.hc   = 1'b0;
        r.last = 1'b0;
        mk_res = r;
    endfunction

endpackage

// ===== rtl/sd_card_spi_host_engine.sv =====
// top level: sd card spi mode host engine with result queue
//
// channel  dir  handshake           beat
// in       in   i_valid / o_stall   mode, operation, block_number, rx_byte, write_byte
// out      out  o_valid / i_stall   kind, tx_byte, select_card, read_byte, status, ...
// cfg      in   i_cfg_we            i_cfg_idx, i_cfg_data
//
// each input beat is decoded into zero, one or two results (two for read data)
// results go to a 4-entry queue; a beat is taken whenever at least two entries are free
// one beat per cycle while the output side drains one result per cycle and two entries stay free
// results are registered in the queue before they reach the output
// synchronous active-low reset clears state and queue, no clearing pass
`include "assert_macros.svh"

module sd_card_spi_host_engine import sdh_pkg::*; #(
    parameter int INIT_IDLE_BYTES_P = INIT_IDLE_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_block_number,
    input  logic [7:0]  i_rx_byte,
    input  logic [7:0]  i_write_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_tx_byte,
    output logic        o_select_card,
    output logic [7:0]  o_read_byte,
    output logic        o_status,
    output logic        o_high_capacity,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    localparam int PW = $clog2(OUT_DEPTH);

    logic [7:0]  r_lim_resp;
    logic [15:0] r_lim_idle, r_lim_ifc, r_lim_opc, r_lim_tok, r_lim_busy;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_step, n_step;
    logic [31:0] r_arg, n_arg;
    logic [9:0]  r_bc, n_bc;
    logic [15:0] r_retry, n_retry;
    logic [15:0] r_wait, n_wait;
    logic        r_hc, n_hc;
    logic        r_v2, n_v2;
    logic [7:0]  r_lresp, n_lresp;

    t_res        res0, res1, res0_f, res1_f;
    logic [1:0]  nres;
    logic        do_start, do_fin, fin_st;
    t_phase      st_p;
    logic [31:0] st_a;
    logic [15:0] retry_inc;
    logic [9:0]  bc_inc;
    logic [5:0]  cur_cmd;

    t_res        r_q [OUT_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt, n_cnt;
    logic        acc, pop;

    assign o_stall = (r_cnt > (PW+1)'(OUT_DEPTH - 2));
    assign acc     = i_valid && !o_stall;
    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim_resp <= 8'd254;
            r_lim_idle <= 16'd240;
            r_lim_ifc  <= 16'd254;
            r_lim_opc  <= 16'd4094;
            r_lim_tok  <= 16'd65534;
            r_lim_busy <= 16'd65534;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RESP_WAIT: r_lim_resp <= i_cfg_data[7:0];
                CFG_IDLE_RTRY: r_lim_idle <= i_cfg_data;
                CFG_IFC_RTRY:  r_lim_ifc  <= i_cfg_data;
                CFG_OPC_RTRY:  r_lim_opc  <= i_cfg_data;
                CFG_TOK_WAIT:  r_lim_tok  <= i_cfg_data;
                CFG_BUSY_WAIT: r_lim_busy <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign retry_inc = r_retry + 16'd1;
    assign bc_inc    = r_bc + 10'd1;
    assign cur_cmd   = cmd_of(r_phase);

    always_comb begin
        n_phase  = r_phase;
        n_step   = r_step;
        n_arg    = r_arg;
        n_bc     = r_bc;
        n_retry  = r_retry;
        n_wait   = r_wait;
        n_hc     = r_hc;
        n_v2     = r_v2;
        n_lresp  = r_lresp;
        res0     = mk_res(KIND_XCHG, BYTE_IDLE, 1'b1, 8'd0, 1'b0);
        res1     = mk_res(KIND_XCHG, BYTE_IDLE, 1'b1, 8'd0, 1'b0);
        nres     = 2'd1;
        do_start = 1'b0;
        do_fin   = 1'b0;
        fin_st   = 1'b0;
        st_p     = PH_IDLE;
        st_a     = '0;

        case (i_mode)
            MODE_REQ: begin
                if (r_phase == PH_IDLE) begin
                    case (i_operation)
                        OP_INIT: begin
                            n_v2    = 1'b1;
                            n_phase = PH_INIT_IDLE;
                            n_bc    = '0;
                            n_retry = '0;
                            res0    = mk_res(KIND_XCHG, BYTE_IDLE, 1'b0, 8'd0, 1'b0);
                        end
                        OP_READ: begin
                            do_start = 1'b1; st_p = PH_RD_CMD; st_a = i_block_number;
                        end
                        OP_WRITE: begin
                            do_start = 1'b1; st_p = PH_WR_CMD; st_a = i_block_number;
                        end
                        default: begin
                            do_fin = 1'b1; fin_st = 1'b1;
                        end
                    endcase
                end else begin
                    nres = 2'd0;
                end
            end
            MODE_CARD: begin
                case (r_phase)
                    PH_INIT_IDLE: begin
                        n_bc = bc_inc;
                        if (bc_inc < 10'(INIT_IDLE_BYTES_P)) begin
                            res0 = mk_res(KIND_XCHG, BYTE_IDLE, 1'b0, 8'd0, 1'b0);
                        end else begin
                            n_retry = '0; do_start = 1'b1; st_p = PH_CMD0; st_a = '0;
                        end
                    end
                    PH_GAP: begin
                        n_bc = bc_inc;
                        if (bc_inc < 10'd2) begin
                            res0 = mk_res(KIND_XCHG, BYTE_IDLE, 1'b0, 8'd0, 1'b0);
                        end else begin
                            n_retry = '0; do_start = 1'b1; st_p = PH_CMD8; st_a = ARG_IFCOND;
                        end
                    end
                    PH_CMD0, PH_CMD8, PH_CMD55, PH_ACMD41, PH_CMD58, PH_RD_CMD,
                    PH_WR_CMD: begin
                        if (r_step < 4'd5) begin
                            n_step = r_step + 4'd1;
                            res0 = mk_res(KIND_XCHG, frame_byte(cur_cmd, r_arg, r_step + 4'd1),
                                          1'b1, 8'd0, 1'b0);
                        end else if (r_step == 4'd5) begin
                            n_step = 4'd6;
                            n_wait = '0;
                        end else if (r_step == 4'd6) begin
                            if (i_rx_byte == BYTE_IDLE && r_wait <= {8'd0, r_lim_resp}) begin
                                n_wait = r_wait + 16'd1;
                            end else begin
                                n_lresp = i_rx_byte;
                                n_step  = (i_rx_byte == 8'd0 && cur_cmd == CMD_READ_OCR)
                                          ? 4'd7 : 4'd11;
                            end
                        end else if (r_step < 4'd11) begin
                            if (r_step == 4'd7) n_hc = i_rx_byte[6];
                            n_step = r_step + 4'd1;
                        end else begin
                            case (r_phase)
                                PH_CMD0: begin
                                    if (r_lresp == R1_IDLE) begin
                                        n_phase = PH_GAP;
                                        n_bc    = '0;
                                        res0 = mk_res(KIND_XCHG, BYTE_IDLE, 1'b0, 8'd0, 1'b0);
                                    end else if (r_retry > r_lim_idle) begin
                                        do_fin = 1'b1; fin_st = 1'b1;
                                    end else begin
                                        n_retry = retry_inc;
                                        do_start = 1'b1; st_p = PH_CMD0; st_a = '0;
                                    end
                                end
                                PH_CMD8: begin
                                    if (r_lresp == R1_IDLE) begin
                                        n_retry = '0;
                                        do_start = 1'b1; st_p = PH_CMD55; st_a = '0;
                                    end else if (r_retry > r_lim_ifc) begin
                                        n_v2 = 1'b0; n_retry = '0;
                                        do_start = 1'b1; st_p = PH_CMD55; st_a = '0;
                                    end else begin
                                        n_retry = retry_inc;
                                        do_start = 1'b1; st_p = PH_CMD8; st_a = ARG_IFCOND;
                                    end
                                end
                                PH_CMD55: begin
                                    do_start = 1'b1; st_p = PH_ACMD41; st_a = ARG_HCS;
                                end
                                PH_ACMD41: begin
                                    n_retry = retry_inc;
                                    if (retry_inc > r_lim_opc) begin
                                        do_fin = 1'b1; fin_st = 1'b1;
                                    end else if (r_lresp == 8'd0) begin
                                        n_hc = 1'b0; n_retry = '0;
                                        if (r_v2) begin
                                            do_start = 1'b1; st_p = PH_CMD58; st_a = '0;
                                        end else begin
                                            do_fin = 1'b1; fin_st = 1'b0;
                                        end
                                    end else begin
                                        do_start = 1'b1; st_p = PH_CMD55; st_a = '0;
                                    end
                                end
                                PH_CMD58: begin
                                    if (r_lresp == 8'd0 || r_retry > r_lim_ifc) begin
                                        do_fin = 1'b1; fin_st = 1'b0;
                                    end else begin
                                        n_retry = retry_inc;
                                        do_start = 1'b1; st_p = PH_CMD58; st_a = '0;
                                    end
                                end
                                PH_RD_CMD: begin
                                    if (r_lresp != 8'd0) begin
                                        do_fin = 1'b1; fin_st = 1'b1;
                                    end else begin
                                        n_phase = PH_RD_TOKEN; n_wait = '0;
                                    end
                                end
                                PH_WR_CMD: begin
                                    if (r_lresp != 8'd0) begin
                                        do_fin = 1'b1; fin_st = 1'b1;
                                    end else begin
                                        n_phase = PH_WR_DATA; n_bc = '0;
                                        res0 = mk_res(KIND_XCHG, TOKEN_START, 1'b1, 8'd0, 1'b0);
                                    end
                                end
                                default: begin
                                    do_fin = 1'b1; fin_st = 1'b1;
                                end
                            endcase
                        end
                    end
                    PH_RD_TOKEN: begin
                        if (i_rx_byte == TOKEN_START) begin
                            n_phase = PH_RD_DATA; n_bc = '0;
                        end else if (r_wait > r_lim_tok) begin
                            do_fin = 1'b1; fin_st = 1'b1;
                        end else begin
                            n_wait = r_wait + 16'd1;
                        end
                    end
                    PH_RD_DATA: begin
                        n_bc = bc_inc;
                        if (r_bc < 10'(SECTOR_BYTES)) begin
                            res0 = mk_res(KIND_RDATA, 8'd0, 1'b0, i_rx_byte, 1'b0);
                            nres = 2'd2;
                            if (bc_inc >= 10'(SECTOR_BYTES + 3)) begin
                                n_phase = PH_IDLE;
                                res1 = mk_res(KIND_DONE, 8'd0, 1'b0, 8'd0, 1'b0);
                            end
                        end else if (bc_inc >= 10'(SECTOR_BYTES + 3)) begin
                            do_fin = 1'b1; fin_st = 1'b0;
                        end
                    end
                    PH_WR_DATA: begin
                        if (r_bc < 10'(SECTOR_BYTES)) begin
                            n_phase = PH_WR_NEED;
                            res0 = mk_res(KIND_WNEED, 8'd0, 1'b0, 8'd0, 1'b0);
                        end else if (r_bc < 10'(SECTOR_BYTES + 2)) begin
                            n_bc = bc_inc;
                        end else begin
                            n_phase = PH_WR_RESP;
                        end
                    end
                    PH_WR_RESP: begin
                        if ((i_rx_byte & DRESP_MASK) != DRESP_OK) begin
                            do_fin = 1'b1; fin_st = 1'b1;
                        end else begin
                            n_phase = PH_WR_BUSY1; n_wait = '0;
                        end
                    end
                    PH_WR_BUSY1, PH_WR_BUSY2: begin
                        if (i_rx_byte != 8'd0) begin
                            if (r_phase == PH_WR_BUSY2) begin
                                do_fin = 1'b1; fin_st = 1'b0;
                            end else begin
                                n_phase = PH_WR_GAP;
                                res0 = mk_res(KIND_XCHG, BYTE_IDLE, 1'b0, 8'd0, 1'b0);
                            end
                        end else if (r_wait > r_lim_busy) begin
                            do_fin = 1'b1; fin_st = 1'b1;
                        end else begin
                            n_wait = r_wait + 16'd1;
                        end
                    end
                    PH_WR_GAP: begin
                        n_phase = PH_WR_BUSY2;
                    end
                    default: begin
                        nres = 2'd0;
                    end
                endcase
            end
            MODE_WDATA: begin
                if (r_phase == PH_WR_NEED) begin
                    res0    = mk_res(KIND_XCHG, i_write_byte, 1'b1, 8'd0, 1'b0);
                    n_bc    = bc_inc;
                    n_phase = PH_WR_DATA;
                end else begin
                    nres = 2'd0;
                end
            end
            default: begin
                nres = 2'd0;
            end
        endcase

        if (do_start) begin
            n_phase = st_p;
            n_step  = '0;
            n_wait  = '0;
            n_arg   = (!n_hc && (st_p == PH_RD_CMD || st_p == PH_WR_CMD))
                      ? {st_a[22:0], 9'd0} : st_a;
            res0 = mk_res(KIND_XCHG, {2'b01, cmd_of(st_p)}, 1'b1, 8'd0, 1'b0);
        end
        if (do_fin) begin
            n_phase = PH_IDLE;
            res0 = mk_res(KIND_DONE, 8'd0, 1'b0, 8'd0, fin_st);
        end

        res0_f      = res0;
        res1_f      = res1;
        res0_f.hc   = n_hc;
        res1_f.hc   = n_hc;
        res0_f.last = (nres == 2'd1);
        res1_f.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_step  <= '0;
            r_arg   <= '0;
            r_bc    <= '0;
            r_retry <= '0;
            r_wait  <= '0;
            r_hc    <= 1'b0;
            r_v2    <= 1'b1;
            r_lresp <= BYTE_IDLE;
        end else if (acc) begin
            r_phase <= n_phase;
            r_step  <= n_step;
            r_arg   <= n_arg;
            r_bc    <= n_bc;
            r_retry <= n_retry;
            r_wait  <= n_wait;
            r_hc    <= n_hc;
            r_v2    <= n_v2;
            r_lresp <= n_lresp;
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (acc) n_cnt = n_cnt + (PW+1)'(nres);
        if (pop) n_cnt = n_cnt - (PW+1)'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (acc) r_wp <= r_wp + PW'(nres);
            if (pop) r_rp <= r_rp + PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && nres != 2'd0) r_q[r_wp] <= res0_f;
        if (acc && nres == 2'd2) r_q[r_wp + PW'(1)] <= res1_f;
    end

    assign o_kind          = r_q[r_rp].kind;
    assign o_tx_byte       = r_q[r_rp].tx;
    assign o_select_card   = r_q[r_rp].sel;
    assign o_read_byte     = r_q[r_rp].rd;
    assign o_status        = r_q[r_rp].st;
    assign o_high_capacity = r_q[r_rp].hc;
    assign o_last          = r_q[r_rp].last;

    `SDH_ASSERT(a_q_bound, r_cnt <= (PW+1)'(OUT_DEPTH), "result queue overflow")
    `SDH_ASSERT(a_acc_room, acc |-> r_cnt <= (PW+1)'(OUT_DEPTH - 2), "beat taken without room")
    `SDH_ASSERT(a_wneed_bc, r_phase == PH_WR_NEED |-> r_bc < 10'(SECTOR_BYTES), "write count off")
    `SDH_ASSERT_ALWAYS(a_rst_q, !i_rst_n |=> r_cnt == '0, "queue not empty after reset")

endmodule
